>>> design/tmhc_pkg.sv
// Shared types, codes and constants for the traffic matrix histogram counter.
package tmhc_pkg;

  localparam int NODES_DEF       = 64;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int BYTES_WIDTH_DEF = 48;

  localparam int NUM_COLL = 13;
  localparam int NUM_BINS = 14;

  localparam logic [1:0] ACT_RECORD    = 2'd0;
  localparam logic [1:0] ACT_READ_PAIR = 2'd1;
  localparam logic [1:0] ACT_READ_COLL = 2'd2;
  localparam logic [1:0] ACT_READ_BIN  = 2'd3;

  typedef struct packed {
    logic sweep;    // write zero at the sweep address, advance it
    logic capture;  // latch the input beat, read the pair stores
    logic commit;   // write back, update counters, load output register
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
  } status_t;

endpackage

>>> design/tmhc_ctrl.sv
// Controller state machine: reset sweep, capture, commit and output valid.
module tmhc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output tmhc_pkg::cmd_t    cmd,
  input  tmhc_pkg::status_t status
);
  import tmhc_pkg::*;

  typedef enum logic [1:0] {ST_SWEEP, ST_IDLE, ST_CALC} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   commit;

  // commit only when the output register is free or being drained
  assign commit = (state_r == ST_CALC) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_SWEEP: if (status.sweep_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_CALC;
      ST_CALC:  if (commit) state_nxt = ST_IDLE;
      default:  state_nxt = ST_SWEEP;
    endcase
  end

  always_comb begin
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = out_valid_r;
  assign cmd.sweep   = (state_r == ST_SWEEP);
  assign cmd.capture = (state_r == ST_IDLE) && in_valid;
  assign cmd.commit  = commit;

endmodule

>>> design/tmhc_dp.sv
// Datapath: pair count and byte stores, kind and size-bin counters, output register.
module tmhc_dp #(
  parameter int NODES       = tmhc_pkg::NODES_DEF,
  parameter int COUNT_WIDTH = tmhc_pkg::COUNT_WIDTH_DEF,
  parameter int BYTES_WIDTH = tmhc_pkg::BYTES_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tmhc_pkg::cmd_t    cmd,
  output tmhc_pkg::status_t status,
  input  logic [1:0]        in_action,
  input  logic [3:0]        in_collective_kind,
  input  logic [5:0]        in_src_node,
  input  logic [5:0]        in_dst_node,
  input  logic [31:0]       in_msg_len,
  input  logic [3:0]        in_counter_index,
  output logic [31:0]       out_pair_msg_count,
  output logic [47:0]       out_pair_byte_total,
  output logic [31:0]       out_counter_value,
  output logic [3:0]        out_size_bin
);
  import tmhc_pkg::*;

  localparam int PAIR_DEPTH = NODES * NODES;
  localparam int PAIR_AW    = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;

  // bin i holds lengths up to 16 * 4^i; above 256 MiB falls in the last bin
  function automatic logic [3:0] size_bin_of(input logic [31:0] len);
    logic [3:0] bin;
    bin = 4'(NUM_BINS - 1);
    for (int i = NUM_BINS - 2; i >= 0; i--) begin
      if (len <= (32'd16 << (2 * i))) bin = 4'(i);
    end
    return bin;
  endfunction

  logic [COUNT_WIDTH-1:0] cnt_mem [PAIR_DEPTH];
  logic [BYTES_WIDTH-1:0] byt_mem [PAIR_DEPTH];

  logic [COUNT_WIDTH-1:0] coll_r [NUM_COLL];
  logic [COUNT_WIDTH-1:0] bins_r [NUM_BINS];

  logic [PAIR_AW-1:0]     sweep_addr_r;
  logic [PAIR_AW-1:0]     rd_addr;
  logic                   rd_pair_ok;

  // captured beat
  logic [1:0]             act_r;
  logic [3:0]             kind_r;
  logic [31:0]            len_r;
  logic [3:0]             idx_r;
  logic [3:0]             bin_r;
  logic                   pair_ok_r;
  logic [PAIR_AW-1:0]     addr_r;
  logic [COUNT_WIDTH-1:0] rd_cnt_r;
  logic [BYTES_WIDTH-1:0] rd_byt_r;

  logic [COUNT_WIDTH-1:0] cnt_new;
  logic [BYTES_WIDTH:0]   byt_sum;
  logic [BYTES_WIDTH-1:0] byt_new;
  logic [3:0]             kind_idx;
  logic                   kind_ok;
  logic [COUNT_WIDTH-1:0] coll_cur, coll_new;
  logic [COUNT_WIDTH-1:0] bin_cur, bin_new;
  logic [3:0]             ridx_coll;
  logic [COUNT_WIDTH-1:0] rd_cv;

  logic                   mem_we;
  logic [PAIR_AW-1:0]     wr_addr;
  logic [COUNT_WIDTH-1:0] wr_cnt;
  logic [BYTES_WIDTH-1:0] wr_byt;

  logic [COUNT_WIDTH-1:0] pc_sel, cv_sel;
  logic [BYTES_WIDTH-1:0] pb_sel;
  logic [3:0]             bin_sel;
  logic [63:0]            pc_ext, cv_ext, pb_ext;

  assign rd_pair_ok = (9'(in_src_node) < 9'(NODES)) && (9'(in_dst_node) < 9'(NODES));
  assign rd_addr    = PAIR_AW'(in_src_node) * PAIR_AW'(NODES) + PAIR_AW'(in_dst_node);

  assign status.sweep_last = (sweep_addr_r == PAIR_AW'(PAIR_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_addr_r <= '0;
    end else if (cmd.sweep) begin
      sweep_addr_r <= sweep_addr_r + PAIR_AW'(1);
    end
  end

  // capture registers and registered store read
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r     <= in_action;
      kind_r    <= in_collective_kind;
      len_r     <= in_msg_len;
      idx_r     <= in_counter_index;
      bin_r     <= size_bin_of(in_msg_len);
      pair_ok_r <= rd_pair_ok;
      addr_r    <= rd_addr;
      rd_cnt_r  <= cnt_mem[rd_addr];
      rd_byt_r  <= byt_mem[rd_addr];
    end
  end

  // saturating pair updates
  assign cnt_new = (rd_cnt_r == '1) ? rd_cnt_r : rd_cnt_r + COUNT_WIDTH'(1);
  assign byt_sum = {1'b0, rd_byt_r} + (BYTES_WIDTH + 1)'(len_r);
  assign byt_new = byt_sum[BYTES_WIDTH] ? '1 : byt_sum[BYTES_WIDTH-1:0];

  assign mem_we  = cmd.sweep || (cmd.commit && (act_r == ACT_RECORD) && pair_ok_r);
  assign wr_addr = cmd.sweep ? sweep_addr_r : addr_r;
  assign wr_cnt  = cmd.sweep ? '0 : cnt_new;
  assign wr_byt  = cmd.sweep ? '0 : byt_new;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[wr_addr] <= wr_cnt;
      byt_mem[wr_addr] <= wr_byt;
    end
  end

  // kind and size-bin counters
  assign kind_ok  = (kind_r >= 4'd1) && (kind_r <= 4'(NUM_COLL));
  assign kind_idx = kind_r - 4'd1;
  assign coll_cur = coll_r[kind_idx];
  assign coll_new = (coll_cur == '1) ? coll_cur : coll_cur + COUNT_WIDTH'(1);
  assign bin_cur  = bins_r[bin_r];
  assign bin_new  = (bin_cur == '1) ? bin_cur : bin_cur + COUNT_WIDTH'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COLL; i++) coll_r[i] <= '0;
      for (int i = 0; i < NUM_BINS; i++) bins_r[i] <= '0;
    end else if (cmd.commit && (act_r == ACT_RECORD)) begin
      if (kind_ok) coll_r[kind_idx] <= coll_new;
      bins_r[bin_r] <= bin_new;
    end
  end

  assign ridx_coll = idx_r - 4'd1;

  always_comb begin
    rd_cv = '0;
    case (act_r)
      ACT_READ_COLL: begin
        if ((idx_r >= 4'd1) && (idx_r <= 4'(NUM_COLL))) rd_cv = coll_r[ridx_coll];
      end
      ACT_READ_BIN: begin
        if (idx_r < 4'(NUM_BINS)) rd_cv = bins_r[idx_r];
      end
      default: rd_cv = '0;
    endcase
  end

  // result selection
  always_comb begin
    pc_sel  = '0;
    pb_sel  = '0;
    cv_sel  = '0;
    bin_sel = '0;
    case (act_r)
      ACT_RECORD: begin
        if (pair_ok_r) begin
          pc_sel = cnt_new;
          pb_sel = byt_new;
        end
        cv_sel  = bin_new;
        bin_sel = bin_r;
      end
      ACT_READ_PAIR: begin
        if (pair_ok_r) begin
          pc_sel = rd_cnt_r;
          pb_sel = rd_byt_r;
        end
      end
      default: cv_sel = rd_cv;
    endcase
  end

  assign pc_ext = 64'(pc_sel);
  assign pb_ext = 64'(pb_sel);
  assign cv_ext = 64'(cv_sel);

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_pair_msg_count  <= pc_ext[31:0];
      out_pair_byte_total <= pb_ext[47:0];
      out_counter_value   <= cv_ext[31:0];
      out_size_bin        <= bin_sel;
    end
  end

endmodule

>>> design/traffic_matrix_histogram_counter.sv
// Top level of the traffic matrix histogram counter.
//
// Message traffic monitor. Each input beat is one action: a record event
// (collective kind, source node, destination node, length) or a read of a
// pair entry, a collective-kind counter or a size-bin counter. A record adds
// one to the kind counter (kinds 1..13; kind 0 is point-to-point and is not
// counted), one to the pair's message count, the length to the pair's byte
// total and one to the size bin of the length (bin 0 up to 16 bytes, each
// following bin four times larger up to 256 MiB, bin 13 above that). All
// counters saturate. Every beat gives exactly one result beat. A record
// returns the updated pair values, the updated bin count and the bin; reads
// return the selected values with the other fields zero. Nodes at or above
// NODES address no pair and read as zero. Each item passes through the
// registered read of the pair stores and then the update and write-back;
// no new item is accepted until the last one is written back, and a full
// output register that is not drained stalls the write-back. After reset
// the pair stores are cleared by a sweep over all NODES*NODES entries (4096
// at the default), during which in_ready stays low.
module traffic_matrix_histogram_counter #(
  parameter int NODES       = tmhc_pkg::NODES_DEF,
  parameter int COUNT_WIDTH = tmhc_pkg::COUNT_WIDTH_DEF,
  parameter int BYTES_WIDTH = tmhc_pkg::BYTES_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_collective_kind,
  input  logic [5:0]  in_src_node,
  input  logic [5:0]  in_dst_node,
  input  logic [31:0] in_msg_len,
  input  logic [3:0]  in_counter_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pair_msg_count,
  output logic [47:0] out_pair_byte_total,
  output logic [31:0] out_counter_value,
  output logic [3:0]  out_size_bin
);
  import tmhc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing: sweep, accept, update, hand off to output register
  tmhc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // stores, counters and result register
  tmhc_dp #(
    .NODES       (NODES),
    .COUNT_WIDTH (COUNT_WIDTH),
    .BYTES_WIDTH (BYTES_WIDTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_action           (in_action),
    .in_collective_kind  (in_collective_kind),
    .in_src_node         (in_src_node),
    .in_dst_node         (in_dst_node),
    .in_msg_len          (in_msg_len),
    .in_counter_index    (in_counter_index),
    .out_pair_msg_count  (out_pair_msg_count),
    .out_pair_byte_total (out_pair_byte_total),
    .out_counter_value   (out_counter_value),
    .out_size_bin        (out_size_bin)
  );

endmodule

>>> design/tmhc_chk.sv
// Port-level checker for the traffic matrix histogram counter, with its bind.
module tmhc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pair_msg_count,
  input logic [47:0] out_pair_byte_total,
  input logic [31:0] out_counter_value,
  input logic [3:0]  out_size_bin
);
  import tmhc_pkg::*;

  // result beat holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pair_msg_count) &&
      $stable(out_pair_byte_total) && $stable(out_counter_value) && $stable(out_size_bin))
    else $error("result beat changed while stalled");

  // one item at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while previous item still in work");

  // size bin always in range
  a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_size_bin < 4'(NUM_BINS))
    else $error("size bin out of range");

  // reset starts the clearing sweep with no beats in flight
  a_sweep_start: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready && !out_valid)
    else $error("block ready or valid right after reset");

endmodule

bind traffic_matrix_histogram_counter tmhc_chk u_tmhc_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_pair_msg_count  (out_pair_msg_count),
  .out_pair_byte_total (out_pair_byte_total),
  .out_counter_value   (out_counter_value),
  .out_size_bin        (out_size_bin)
);

>>> verif/testbench.sv
// Self-checking testbench for the traffic matrix histogram counter.
`timescale 1ns / 1ps

module testbench;
  import tmhc_pkg::*;

  localparam int RANDOM_BEATS = 1600;
  // Longest quiet stretch tolerated: covers the clearing sweep
  // after reset and the long output hold-off, several times over.
  localparam int IDLE_LIMIT   = 20000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int PAIRS        = NODES_DEF * NODES_DEF;

  localparam logic [47:0] BYTES_FULL = '1;

  // One input beat and one result beat, at the port widths.
  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  kind;
    logic [5:0]  src;
    logic [5:0]  dst;
    logic [31:0] len;
    logic [3:0]  idx;
  } event_beat_t;

  typedef struct packed {
    logic [31:0] msg_count;
    logic [47:0] byte_total;
    logic [31:0] counter_value;
    logic [3:0]  size_bin;
  } report_beat_t;

  // Directed row: stimulus plus, where obvious by inspection, the pinned report.
  typedef struct packed {
    event_beat_t  stim;
    logic         pinned;
    report_beat_t report;
  } directed_row_t;

  // Directed table. Rows with pinned=1 carry a hand-written report; the rest
  // are checked against the traffic model below.
  localparam directed_row_t DIRECTED [25] = '{
    // freshly swept stores read back as zero, including the extreme corner
    '{'{ACT_READ_PAIR, 4'd0,  6'd0,  6'd0,  32'd0, 4'd0},  1'b1, '{32'd0, 48'd0, 32'd0, 4'd0}},
    '{'{ACT_READ_PAIR, 4'd0,  6'd63, 6'd63, 32'd0, 4'd0},  1'b1, '{32'd0, 48'd0, 32'd0, 4'd0}},
    '{'{ACT_READ_COLL, 4'd0,  6'd0,  6'd0,  32'd0, 4'd1},  1'b1, '{32'd0, 48'd0, 32'd0, 4'd0}},
    // collective read with no counter behind the index
    '{'{ACT_READ_COLL, 4'd0,  6'd0,  6'd0,  32'd0, 4'd0},  1'b1, '{32'd0, 48'd0, 32'd0, 4'd0}},
    '{'{ACT_READ_COLL, 4'd0,  6'd0,  6'd0,  32'd0, 4'd15}, 1'b1, '{32'd0, 48'd0, 32'd0, 4'd0}},
    '{'{ACT_READ_BIN,  4'd0,  6'd0,  6'd0,  32'd0, 4'd0},  1'b1, '{32'd0, 48'd0, 32'd0, 4'd0}},
    // size-bin read out of range
    '{'{ACT_READ_BIN,  4'd0,  6'd0,  6'd0,  32'd0, 4'd15}, 1'b1, '{32'd0, 48'd0, 32'd0, 4'd0}},
    // first records: point-to-point zero length, then all-ones length (huge bin)
    '{'{ACT_RECORD,    4'd0,  6'd0,  6'd0,  32'd0, 4'd0},  1'b1, '{32'd1, 48'd0, 32'd1, 4'd0}},
    '{'{ACT_RECORD,    4'd13, 6'd63, 6'd63, 32'hFFFF_FFFF, 4'd0}, 1'b1,
      '{32'd1, 48'hFFFF_FFFF, 32'd1, 4'd13}},
    '{'{ACT_RECORD,    4'd1,  6'd63, 6'd0,  32'd16, 4'd0}, 1'b1, '{32'd1, 48'd16, 32'd2, 4'd0}},
    // unknown kind, length just past the first bin edge
    '{'{ACT_RECORD,    4'd14, 6'd0,  6'd63, 32'd17, 4'd0}, 1'b1, '{32'd1, 48'd17, 32'd1, 4'd1}},
    '{'{ACT_RECORD,    4'd15, 6'd1,  6'd2,  32'd64, 4'd0},  1'b0, '0},
    '{'{ACT_RECORD,    4'd2,  6'd1,  6'd2,  32'd65, 4'd0},  1'b0, '0},
    '{'{ACT_RECORD,    4'd3,  6'd2,  6'd1,  32'd1024, 4'd0}, 1'b0, '0},
    '{'{ACT_RECORD,    4'd4,  6'd5,  6'd6,  32'h0040_0000, 4'd0}, 1'b0, '0},
    // last finite bin edge at 256 MiB and one byte beyond it
    '{'{ACT_RECORD,    4'd5,  6'd5,  6'd6,  32'h1000_0000, 4'd0}, 1'b0, '0},
    '{'{ACT_RECORD,    4'd6,  6'd7,  6'd8,  32'h1000_0001, 4'd0}, 1'b0, '0},
    // back-to-back hits on one pair exercise the write-back path
    '{'{ACT_RECORD,    4'd0,  6'd0,  6'd0,  32'hFFFF_FFFF, 4'd0}, 1'b0, '0},
    '{'{ACT_RECORD,    4'd7,  6'd0,  6'd0,  32'hFFFF_FFFF, 4'd0}, 1'b0, '0},
    '{'{ACT_READ_PAIR, 4'd0,  6'd0,  6'd0,  32'd0, 4'd0},  1'b0, '0},
    '{'{ACT_READ_COLL, 4'd0,  6'd0,  6'd0,  32'd0, 4'd13}, 1'b0, '0},
    '{'{ACT_READ_COLL, 4'd0,  6'd0,  6'd0,  32'd0, 4'd14}, 1'b0, '0},
    '{'{ACT_READ_BIN,  4'd0,  6'd0,  6'd0,  32'd0, 4'd13}, 1'b0, '0},
    '{'{ACT_READ_BIN,  4'd0,  6'd0,  6'd0,  32'd0, 4'd14}, 1'b0, '0},
    '{'{ACT_READ_BIN,  4'd0,  6'd0,  6'd0,  32'd0, 4'd12}, 1'b0, '0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_action;
  logic [3:0]  in_collective_kind;
  logic [5:0]  in_src_node;
  logic [5:0]  in_dst_node;
  logic [31:0] in_msg_len;
  logic [3:0]  in_counter_index;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_pair_msg_count;
  logic [47:0] out_pair_byte_total;
  logic [31:0] out_counter_value;
  logic [3:0]  out_size_bin;

  // Traffic model state: pair stores addressed by {src, dst}, kind counters
  // indexed by kind, size-bin counters indexed by bin.
  logic [31:0] msg_tally  [PAIRS];
  logic [47:0] byte_tally [PAIRS];
  logic [31:0] kind_tally [1:NUM_COLL];
  logic [31:0] bin_tally  [NUM_BINS];

  report_beat_t pending_reports [$];

  int   mismatches   = 0;
  int   idle_cycles  = 0;
  bit   send_calm    = 1'b0;
  bit   recv_calm    = 1'b0;
  bit   hold_request = 1'b0;

  traffic_matrix_histogram_counter dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_collective_kind  (in_collective_kind),
    .in_src_node         (in_src_node),
    .in_dst_node         (in_dst_node),
    .in_msg_len          (in_msg_len),
    .in_counter_index    (in_counter_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_pair_msg_count  (out_pair_msg_count),
    .out_pair_byte_total (out_pair_byte_total),
    .out_counter_value   (out_counter_value),
    .out_size_bin        (out_size_bin)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Saturating +1 for every count-width counter.
  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  // Bin i holds lengths up to 16 * 4^i; past bin 12 (256 MiB) is the huge bin.
  function automatic logic [3:0] size_class(logic [31:0] len);
    for (int i = 0; i < 13; i++) begin
      if ({32'd0, len} <= (64'd16 << (2 * i))) return 4'(i);
    end
    return 4'd13;
  endfunction

  // Applies one accepted beat to the traffic model and returns its report.
  // Node fields are 6 bits wide and NODES is 64, so every pair is addressable.
  function automatic report_beat_t account_beat(event_beat_t b);
    report_beat_t r;
    logic [11:0]  slot;
    logic [48:0]  sum;
    logic [3:0]   bin;
    r    = '0;
    slot = {b.src, b.dst};
    case (b.action)
      ACT_RECORD: begin
        if (b.kind >= 1 && b.kind <= NUM_COLL) kind_tally[b.kind] = bump(kind_tally[b.kind]);
        msg_tally[slot] = bump(msg_tally[slot]);
        sum = {1'b0, byte_tally[slot]} + {17'd0, b.len};
        byte_tally[slot] = (sum > {1'b0, BYTES_FULL}) ? BYTES_FULL : sum[47:0];
        bin = size_class(b.len);
        bin_tally[bin]  = bump(bin_tally[bin]);
        r.msg_count     = msg_tally[slot];
        r.byte_total    = byte_tally[slot];
        r.counter_value = bin_tally[bin];
        r.size_bin      = bin;
      end
      ACT_READ_PAIR: begin
        r.msg_count  = msg_tally[slot];
        r.byte_total = byte_tally[slot];
      end
      ACT_READ_COLL: begin
        if (b.idx >= 1 && b.idx <= NUM_COLL) r.counter_value = kind_tally[b.idx];
      end
      default: begin
        if (b.idx < NUM_BINS) r.counter_value = bin_tally[b.idx];
      end
    endcase
    return r;
  endfunction

  // Random beat: mostly records, nodes biased to a few hot pairs so that
  // counts build up and back-to-back hits on one pair are common, lengths
  // biased toward bin edges and the extremes.
  function automatic event_beat_t random_beat();
    event_beat_t  b;
    logic [5:0]   hot [4];
    logic [31:0]  edge_len;
    int           pick;
    hot = '{6'd0, 6'd1, 6'd62, 6'd63};
    pick = $urandom_range(0, 9);
    if (pick < 6)      b.action = ACT_RECORD;
    else if (pick < 8) b.action = ACT_READ_PAIR;
    else if (pick < 9) b.action = ACT_READ_COLL;
    else               b.action = ACT_READ_BIN;
    b.kind = 4'($urandom_range(0, 15));
    b.idx  = 4'($urandom_range(0, 15));
    b.src  = ($urandom_range(0, 3) != 0) ? hot[$urandom_range(0, 3)] : 6'($urandom_range(0, 63));
    b.dst  = ($urandom_range(0, 3) != 0) ? hot[$urandom_range(0, 3)] : 6'($urandom_range(0, 63));
    case ($urandom_range(0, 5))
      0: b.len = $urandom();
      1: b.len = $urandom_range(0, 64);
      2: begin
        edge_len = 32'd16 << (2 * $urandom_range(0, 12));
        b.len = edge_len + $urandom_range(0, 2) - 32'd1;
      end
      3: b.len = 32'hFFFF_FFFF - $urandom_range(0, 3);
      4: b.len = $urandom_range(0, 32'h0010_0000);
      default: b.len = $urandom() >> $urandom_range(0, 31);
    endcase
    return b;
  endfunction

  // Offers one beat after a random gap and records the expected report at
  // the accepting edge. in_valid gets a single assignment per time step:
  // it is lowered only when a gap follows.
  task automatic offer_beat(input event_beat_t b, input logic pinned, input report_beat_t fixed);
    int           gap;
    report_beat_t predicted;
    if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_action          <= b.action;
    in_collective_kind <= b.kind;
    in_src_node        <= b.src;
    in_dst_node        <= b.dst;
    in_msg_len         <= b.len;
    in_counter_index   <= b.idx;
    do @(posedge clk); while (!in_ready);
    predicted = account_beat(b);
    pending_reports.push_back(pinned ? fixed : predicted);
  endtask

  // Stimulus: reset, directed table, then the random run.
  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_action          = ACT_RECORD;
    in_collective_kind = '0;
    in_src_node        = '0;
    in_dst_node        = '0;
    in_msg_len         = '0;
    in_counter_index   = '0;
    foreach (msg_tally[i])  msg_tally[i]  = '0;
    foreach (byte_tally[i]) byte_tally[i] = '0;
    foreach (kind_tally[i]) kind_tally[i] = '0;
    foreach (bin_tally[i])  bin_tally[i]  = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < $size(DIRECTED); r++)
      offer_beat(DIRECTED[r].stim, DIRECTED[r].pinned, DIRECTED[r].report);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      // Midway the output side stops draining while beats keep coming.
      if (n == RANDOM_BEATS / 2) begin
        hold_request = 1'b1;
        send_calm    = 1'b1;
      end
      offer_beat(random_beat(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Output side: random stall per beat, calm stretches, one long hold-off.
  initial begin
    int stall;
    out_ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
        stall = recv_calm ? 0 : $urandom_range(0, 13);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Report checker: every accepted result beat against the oldest expectation.
  always @(posedge clk) begin
    report_beat_t got;
    report_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_pair_msg_count, out_pair_byte_total, out_counter_value, out_size_bin};
      if (pending_reports.size() == 0) begin
        $error("unexpected result beat: no report pending");
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        if (got.msg_count !== want.msg_count) begin
          $error("pair_msg_count: expected %0d, got %0d", want.msg_count, got.msg_count);
          mismatches++;
        end
        if (got.byte_total !== want.byte_total) begin
          $error("pair_byte_total: expected %0d, got %0d", want.byte_total, got.byte_total);
          mismatches++;
        end
        if (got.counter_value !== want.counter_value) begin
          $error("counter_value: expected %0d, got %0d", want.counter_value, got.counter_value);
          mismatches++;
        end
        if (got.size_bin !== want.size_bin) begin
          $error("size_bin: expected %0d, got %0d", want.size_bin, got.size_bin);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any beat moving.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
